// ===== hw/rtl/rpba_pkg.sv =====
// Shared types, constants and helpers of the rotating priority bank arbiter.
`default_nettype none

package rpba_pkg;

	localparam int NUM_PORTS       = 8;
	localparam int PORT_IDX_W      = 3;
	localparam int MOD_W           = 11;
	localparam int NP_W            = 4;
	localparam int NM_W            = 12;
	localparam int OUT_CNT_W       = 32;
	localparam int CFG_IDX_W       = 1;
	localparam int CFG_DATA_W      = 12;

	localparam int DEF_MAX_PROCS   = 8;
	localparam int DEF_MAX_MODULES = 2048;
	localparam int DEF_COUNT_WIDTH = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_NUM_PROCS   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_MODULES = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_VISIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             start_run;
		logic [MOD_W-1:0] req_module_0;
		logic [MOD_W-1:0] req_module_1;
		logic [MOD_W-1:0] req_module_2;
		logic [MOD_W-1:0] req_module_3;
		logic [MOD_W-1:0] req_module_4;
		logic [MOD_W-1:0] req_module_5;
		logic [MOD_W-1:0] req_module_6;
		logic [MOD_W-1:0] req_module_7;
	} req_item_t;

	typedef struct packed {
		logic [NUM_PORTS-1:0]  grant_mask;
		logic [NUM_PORTS-1:0]  wait_mask;
		logic [PORT_IDX_W-1:0] next_start;
		logic                  all_served;
		logic [OUT_CNT_W-1:0]  cycle_number;
	} res_item_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic step;
		logic emit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic last_visit;
	} status_t;

	function automatic logic [MOD_W-1:0] req_of(input req_item_t it,
	                                            input logic [PORT_IDX_W-1:0] idx);
		logic [MOD_W-1:0] r;
		unique case (idx)
			3'd0: r = it.req_module_0;
			3'd1: r = it.req_module_1;
			3'd2: r = it.req_module_2;
			3'd3: r = it.req_module_3;
			3'd4: r = it.req_module_4;
			3'd5: r = it.req_module_5;
			3'd6: r = it.req_module_6;
			3'd7: r = it.req_module_7;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rpba_ifs.sv =====
// Valid/ready channel interfaces for request and result beats.
`default_nettype none

interface rpba_req_if;
	logic                 valid;
	logic                 ready;
	rpba_pkg::req_item_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface rpba_res_if;
	logic                 valid;
	logic                 ready;
	rpba_pkg::res_item_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rotating_priority_bank_arbiter.sv =====
// Rotating priority memory bank arbiter: one request beat in, one result beat out.
//
// Each request beat is one memory cycle: every processor names the module it wants, and
// processors are visited in rotating order from the first one denied in the previous
// cycle (the start stays put if nobody was denied). An idle processor claims its new
// request; a waiting one retries the module it holds. The first claim on a module wins,
// a loser holds its request, counts a denial and waits. The result beat carries grant and
// wait masks, the next start point, whether every processor has fewer denials than
// elapsed cycles, and the saturating cycle count of the run. Setting start_run clears the
// run before the beat is arbitrated. Module numbers at or above num_modules clamp to the
// last module; num_procs and num_modules of zero act as one and values above the maximum
// act as the maximum. A beat is captured, then each processor is visited in turn by the
// single claim unit, which compares the module against those already claimed in this
// beat, and then the output register is loaded once it is free. A new beat is taken
// as soon as the result is registered, even while it still waits to be taken downstream.
// Configuration is a plain write port and must be written only while the block is idle.
`default_nettype none

module rotating_priority_bank_arbiter #(
	parameter int MAX_PROCS   = rpba_pkg::DEF_MAX_PROCS,
	parameter int MAX_MODULES = rpba_pkg::DEF_MAX_MODULES,
	parameter int COUNT_WIDTH = rpba_pkg::DEF_COUNT_WIDTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [rpba_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [rpba_pkg::CFG_DATA_W-1:0] cfg_wdata,
	rpba_req_if.sink                             req_ch,
	rpba_res_if.source                           res_ch
);

	rpba_pkg::cmd_t    cmd;
	rpba_pkg::status_t status;

	// Sequencer: owns the handshakes and the output valid flag.
	rpba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_ch.valid),
		.req_ready (req_ch.ready),
		.res_valid (res_ch.valid),
		.res_ready (res_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath: configuration, per-processor state and the result register.
	rpba_datapath #(
		.MAX_PROCS   (MAX_PROCS),
		.MAX_MODULES (MAX_MODULES),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.req_data  (req_ch.data),
		.cmd       (cmd),
		.status    (status),
		.res_data  (res_ch.data)
	);

	// Never overwrite a result beat that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!res_ch.valid || res_ch.ready))
		else $error("result register loaded while a beat was still pending");

	// One beat in flight: after acceptance the input side drops ready.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_ch.valid && req_ch.ready) |=> !req_ch.ready)
		else $error("request accepted while another was being arbitrated");

	// A processor is either granted or denied in a cycle, never both.
	a_masks_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		res_ch.valid |-> ((res_ch.data.grant_mask & res_ch.data.wait_mask) == '0))
		else $error("processor both granted and denied");

endmodule

`default_nettype wire

// ===== hw/rtl/rpba_ctrl.sv =====
// Sequencer: accept a beat, visit each processor once, post the result.
`default_nettype none

module rpba_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	output logic                   res_valid,
	input  wire logic              res_ready,
	input  wire rpba_pkg::status_t status,
	output rpba_pkg::cmd_t         cmd
);

	rpba_pkg::state_t state_q, state_d;
	logic             res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rpba_pkg::ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			rpba_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = rpba_pkg::ST_VISIT;
				end
			end
			rpba_pkg::ST_VISIT: begin
				cmd.step = 1'b1;
				if (status.last_visit) begin
					state_d = rpba_pkg::ST_DONE;
				end
			end
			rpba_pkg::ST_DONE: begin
				// hold until the output register is free
				if (!res_valid_q || res_ready) begin
					cmd.emit = 1'b1;
					state_d  = rpba_pkg::ST_IDLE;
				end
			end
			default: state_d = rpba_pkg::ST_IDLE;
		endcase
	end

	assign res_valid = res_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rpba_datapath.sv =====
// Arbitration datapath: per-processor state, claim check and result register.
`default_nettype none

module rpba_datapath #(
	parameter int MAX_PROCS   = rpba_pkg::DEF_MAX_PROCS,
	parameter int MAX_MODULES = rpba_pkg::DEF_MAX_MODULES,
	parameter int COUNT_WIDTH = rpba_pkg::DEF_COUNT_WIDTH
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [rpba_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  wire logic [rpba_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  wire rpba_pkg::req_item_t                 req_data,
	input  wire rpba_pkg::cmd_t                      cmd,
	output rpba_pkg::status_t                        status,
	output rpba_pkg::res_item_t                      res_data
);

	localparam int PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int MW = rpba_pkg::MOD_W;
	localparam int CW = COUNT_WIDTH;

	// configuration
	logic [rpba_pkg::NP_W-1:0] num_procs_q;
	logic [rpba_pkg::NM_W-1:0] num_modules_q;
	logic [rpba_pkg::NP_W-1:0] np_eff;
	logic [rpba_pkg::NM_W-1:0] nm_eff;

	// run state
	logic [MW-1:0]        held_mod_q [MAX_PROCS];
	logic [MAX_PROCS-1:0] held_vld_q;
	logic [CW-1:0]        den_q      [MAX_PROCS];
	logic [CW-1:0]        elapsed_q;
	logic [PW-1:0]        start_q;

	// per-beat working state
	logic [MW-1:0]        req_q      [MAX_PROCS];
	logic [MW-1:0]        claim_q    [MAX_PROCS];
	logic [MAX_PROCS-1:0] claim_vld_q;
	logic [PW-1:0]        cur_q;
	logic [PW-1:0]        step_q;
	logic [PW-1:0]        next_q;
	logic                 seen_q;
	logic                 served_q;
	logic [rpba_pkg::NUM_PORTS-1:0] grant_q;
	logic [rpba_pkg::NUM_PORTS-1:0] wait_q;

	rpba_pkg::res_item_t  res_q;

	logic [PW-1:0]        st_sel;
	logic [PW-1:0]        first;
	logic [PW-1:0]        cur_nxt;
	logic                 hold;
	logic [MW-1:0]        m_raw;
	logic [MW-1:0]        m_clamp;
	logic                 hit;
	logic [CW-1:0]        den_cur;
	logic [CW-1:0]        den_inc;
	logic [CW-1:0]        elapsed_nxt;
	logic [rpba_pkg::OUT_CNT_W-1:0] cycle_out;
	logic [rpba_pkg::PORT_IDX_W-1:0] cur_port;

	always_comb begin
		if (num_procs_q == '0) begin
			np_eff = rpba_pkg::NP_W'(1);
		end else if (num_procs_q > rpba_pkg::NP_W'(MAX_PROCS)) begin
			np_eff = rpba_pkg::NP_W'(MAX_PROCS);
		end else begin
			np_eff = num_procs_q;
		end
		if (num_modules_q == '0) begin
			nm_eff = rpba_pkg::NM_W'(1);
		end else if (num_modules_q > rpba_pkg::NM_W'(MAX_MODULES)) begin
			nm_eff = rpba_pkg::NM_W'(MAX_MODULES);
		end else begin
			nm_eff = num_modules_q;
		end
	end

	always_comb begin
		st_sel      = req_data.start_run ? '0 : start_q;
		first       = (rpba_pkg::NP_W'(st_sel) < np_eff) ? st_sel : '0;
		elapsed_nxt = req_data.start_run ? CW'(1)
		            : ((elapsed_q == '1) ? elapsed_q : elapsed_q + CW'(1));

		cur_nxt  = (rpba_pkg::NP_W'(cur_q) + rpba_pkg::NP_W'(1) == np_eff) ? '0
		         : cur_q + PW'(1);
		cur_port = rpba_pkg::PORT_IDX_W'(cur_q);

		hold    = held_vld_q[cur_q];
		m_raw   = hold ? held_mod_q[cur_q] : req_q[cur_q];
		m_clamp = ({1'b0, m_raw} >= nm_eff) ? MW'(nm_eff - rpba_pkg::NM_W'(1)) : m_raw;

		hit = 1'b0;
		for (int i = 0; i < MAX_PROCS; i++) begin
			hit = hit | (claim_vld_q[i] && (claim_q[i] == m_clamp));
		end

		den_cur = den_q[cur_q];
		den_inc = (den_cur == '1) ? den_cur : den_cur + CW'(1);

		status.last_visit = (rpba_pkg::NP_W'(step_q) + rpba_pkg::NP_W'(1) == np_eff);
	end

	generate
		if (CW > rpba_pkg::OUT_CNT_W) begin : g_cyc_sat
			assign cycle_out = (|elapsed_q[CW-1:rpba_pkg::OUT_CNT_W]) ? '1
			                 : elapsed_q[rpba_pkg::OUT_CNT_W-1:0];
		end else begin : g_cyc_ext
			assign cycle_out = rpba_pkg::OUT_CNT_W'(elapsed_q);
		end
	endgenerate

	// configuration and run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_procs_q   <= rpba_pkg::NP_W'(MAX_PROCS);
			num_modules_q <= rpba_pkg::NM_W'(MAX_MODULES);
			held_vld_q    <= '0;
			elapsed_q     <= '0;
			start_q       <= '0;
			for (int i = 0; i < MAX_PROCS; i++) begin
				den_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					rpba_pkg::CFG_NUM_PROCS:   num_procs_q   <= cfg_wdata[rpba_pkg::NP_W-1:0];
					rpba_pkg::CFG_NUM_MODULES: num_modules_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.load) begin
				elapsed_q <= elapsed_nxt;
				if (req_data.start_run) begin
					held_vld_q <= '0;
					start_q    <= '0;
					for (int i = 0; i < MAX_PROCS; i++) begin
						den_q[i] <= '0;
					end
				end
			end
			if (cmd.step) begin
				if (hit) begin
					held_vld_q[cur_q] <= 1'b1;
					den_q[cur_q]      <= den_inc;
				end else begin
					held_vld_q[cur_q] <= 1'b0;
				end
			end
			if (cmd.emit) begin
				start_q <= next_q;
			end
		end
	end

	// beat-local working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			claim_vld_q <= '0;
			cur_q       <= '0;
			step_q      <= '0;
			next_q      <= '0;
			seen_q      <= 1'b0;
			served_q    <= 1'b0;
			grant_q     <= '0;
			wait_q      <= '0;
		end else if (cmd.load) begin
			claim_vld_q <= '0;
			cur_q       <= first;
			step_q      <= '0;
			next_q      <= first;
			seen_q      <= 1'b0;
			served_q    <= 1'b1;
			grant_q     <= '0;
			wait_q      <= '0;
		end else if (cmd.step) begin
			claim_vld_q[step_q] <= 1'b1;
			cur_q               <= cur_nxt;
			step_q              <= step_q + PW'(1);
			if (hit) begin
				wait_q[cur_port] <= 1'b1;
				served_q         <= served_q & (den_inc < elapsed_q);
				if (!seen_q) begin
					next_q <= cur_q;
					seen_q <= 1'b1;
				end
			end else begin
				grant_q[cur_port] <= 1'b1;
				served_q          <= served_q & (den_cur < elapsed_q);
			end
		end
	end

	// payload: captured requests, claimed modules, held modules, result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < MAX_PROCS; i++) begin
				req_q[i] <= rpba_pkg::req_of(req_data, rpba_pkg::PORT_IDX_W'(i));
			end
		end
		if (cmd.step) begin
			claim_q[step_q] <= m_clamp;
			if (hit || hold) begin
				held_mod_q[cur_q] <= m_clamp;
			end
		end
		if (cmd.emit) begin
			res_q.grant_mask   <= grant_q;
			res_q.wait_mask    <= wait_q;
			res_q.next_start   <= rpba_pkg::PORT_IDX_W'(next_q);
			res_q.all_served   <= served_q;
			res_q.cycle_number <= cycle_out;
		end
	end

	assign res_data = res_q;

endmodule

`default_nettype wire
